// File: src/apms_pkg.sv
// ----------------------------------------------------------------------------
// apms_pkg: shared types and constants of the light/proximity sequencer
// Holds the sequencer state codes, status codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package apms_pkg;

	localparam int unsigned PROX_CHANNELS = 3;
	localparam int unsigned VW = 31;

	// ceil(2^39 / 625): floor(y * RCP_625 / 2^39) == y / 625 for y < 2^29
	localparam logic [29:0] RCP_625 = 30'd879609303;

	typedef enum logic [2:0] {
		MS_IDLE     = 3'd0,
		MS_ALS      = 3'd1,
		MS_ALS_PEND = 3'd2,
		MS_PS       = 3'd3,
		MS_PS_PEND  = 3'd4
	} meas_state_t;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PROGRESS = 3'd1;
	localparam logic [2:0] ST_BUSY     = 3'd2;
	localparam logic [2:0] ST_DENIED   = 3'd3;
	localparam logic [2:0] ST_MISMATCH = 3'd4;
	localparam logic [2:0] ST_SAME     = 3'd5;
	localparam logic [2:0] ST_IDLEIRQ  = 3'd6;

	localparam logic [1:0] FC_NONE  = 2'd0;
	localparam logic [1:0] FC_LIGHT = 2'd1;
	localparam logic [1:0] FC_PROX  = 2'd2;

	localparam logic [2:0] R_LOFF = 3'd0;
	localparam logic [2:0] R_LRNG = 3'd1;
	localparam logic [2:0] R_POFF = 3'd2;
	localparam logic [2:0] R_PRNG = 3'd3;
	localparam logic [2:0] R_LMSK = 3'd4;
	localparam logic [2:0] R_PMSK = 3'd5;
	localparam logic [2:0] R_CTHR = 3'd6;
	localparam logic [2:0] R_OVF  = 3'd7;

	typedef enum logic [2:0] {
		SQ_IDLE, SQ_DIV, SQ_MUL, SQ_NEXT, SQ_CMP, SQ_OUT
	} seq_state_t;

	// start/done between sequencer and arithmetic unit
	typedef struct packed {
		logic        start;
		logic        invert;
		logic [16:0] s;
		logic [31:0] range;
	} calc_req_t;

	typedef struct packed {
		logic          done;
		logic [VW-1:0] value;
	} calc_rsp_t;

endpackage
`default_nettype wire

// File: src/als_prox_measure_sequencer.sv
// ----------------------------------------------------------------------------
// als_prox_measure_sequencer: light/proximity measurement sequencer
// Trigger and done-interrupt handling with shared per-channel arithmetic.
// ----------------------------------------------------------------------------
// channel  signals                                   direction
// in       in_valid/in_ready, command..sample2       transfer in
// out      out_valid/out_ready, status..value2       transfer out
// cfg      cfg_we, cfg_index, cfg_data               write only
// Triggers and rejected interrupts go from acceptance through SQ_DIV to
// SQ_OUT. A read runs each channel through the shared unit, one channel
// for light and three for proximity (17-step divide of 65536, multiply,
// reciprocal multiply, add; light skips the divide), then compares;
// an overflowed sample ends the read early. Reset clears the state, covered
// flag and last values. in_ready is low from acceptance until the cycle
// after the result transfers out; a low out_ready holds the result.
// ----------------------------------------------------------------------------
`default_nettype none
module als_prox_measure_sequencer import apms_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic          command,
	input  wire logic          sensor_kind,
	input  wire logic [7:0]    irq_flags,
	input  wire logic [15:0]   sample0,
	input  wire logic [15:0]   sample1,
	input  wire logic [15:0]   sample2,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [2:0]         status,
	output logic [1:0]         force_cmd,
	output logic               pushed,
	output logic               sensor_out,
	output logic [VW-1:0]      value0,
	output logic [VW-1:0]      value1,
	output logic [VW-1:0]      value2,
	input  wire logic          cfg_we,
	input  wire logic [2:0]    cfg_index,
	input  wire logic [31:0]   cfg_data
);

	// configuration registers
	logic [15:0] loff_q, poff_q, ovf_q;
	logic [31:0] lrng_q, prng_q;
	logic [7:0]  lmsk_q, pmsk_q;
	logic [VW-1:0] cthr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loff_q <= '0; poff_q <= '0; ovf_q <= 16'hFFFF;
			lrng_q <= 32'h10000; prng_q <= 32'h10000;
			lmsk_q <= 8'd1; pmsk_q <= 8'd28; cthr_q <= VW'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				R_LOFF: loff_q <= cfg_data[15:0];
				R_LRNG: lrng_q <= cfg_data;
				R_POFF: poff_q <= cfg_data[15:0];
				R_PRNG: prng_q <= cfg_data;
				R_LMSK: lmsk_q <= cfg_data[7:0];
				R_PMSK: pmsk_q <= cfg_data[7:0];
				R_CTHR: cthr_q <= cfg_data[VW-1:0];
				R_OVF:  ovf_q  <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	seq_state_t  sq_q, sq_d;
	meas_state_t ms_q;
	logic        cov_q;
	logic [VW-1:0] last_q [6];
	logic        sen_q;
	logic [1:0]  ch_q;
	logic [15:0] smp_q [3];
	logic [7:0]  irq_q;
	logic        cmd_q, kind_q;
	logic [VW-1:0] v_q [3];
	logic [2:0]  st_o_q;
	logic [1:0]  fc_o_q;
	logic        push_o_q, sen_o_q, ovf_hit_q;

	calc_req_t req;
	calc_rsp_t rsp;
	apms_calc u_calc (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	logic [1:0]  nb;
	logic [15:0] raw;
	logic [17:0] ssum;
	logic [15:0] off;
	logic        accept;
	logic        ms_ps, rd_go, pend;
	logic [2:0]  base;

	assign nb = sen_q ? 2'(PROX_CHANNELS) : 2'd1;
	assign raw = smp_q[ch_q];
	assign off = sen_q ? poff_q : loff_q;
	assign ssum = {2'b00, raw} + {{2{off[15]}}, off};
	assign accept = in_valid && in_ready;
	assign base = sen_q ? 3'd3 : 3'd0;

	// interrupt decode: sensor in progress, mask hit, pending request
	assign ms_ps = (ms_q == MS_PS) || (ms_q == MS_PS_PEND);
	assign pend  = (ms_q == MS_ALS_PEND) || (ms_q == MS_PS_PEND);
	assign rd_go = cmd_q && (ms_q inside {MS_ALS, MS_ALS_PEND, MS_PS, MS_PS_PEND}) &&
	               ((irq_q & (ms_ps ? pmsk_q : lmsk_q)) != 8'd0);

	// operand to the shared unit, floor of one
	always_comb begin
		req.start  = (sq_q == SQ_NEXT) && (raw != ovf_q);
		req.invert = sen_q;
		req.s      = (ssum[17] || ssum == 18'd0) ? 17'd1 : ssum[16:0];
		req.range  = sen_q ? prng_q : lrng_q;
	end

	// next state
	always_comb begin
		sq_d = sq_q;
		case (sq_q)
			SQ_IDLE: if (accept) sq_d = SQ_DIV;
			SQ_DIV:  sq_d = rd_go ? SQ_NEXT : SQ_OUT;
			SQ_NEXT: sq_d = (raw == ovf_q) ? SQ_OUT : SQ_MUL;
			SQ_MUL:  if (rsp.done) sq_d = (ch_q + 2'd1 == nb) ? SQ_CMP : SQ_NEXT;
			SQ_CMP:  sq_d = SQ_OUT;
			SQ_OUT:  if (out_ready) sq_d = SQ_IDLE;
			default: sq_d = SQ_IDLE;
		endcase
	end

	// datapath and item decisions; SQ_DIV decodes the accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_q <= SQ_IDLE;
			ms_q <= MS_IDLE;
			cov_q <= 1'b0;
			for (int i = 0; i < 6; i++) last_q[i] <= '0;
		end else begin
			sq_q <= sq_d;
			case (sq_q)
				SQ_IDLE: if (accept) begin
					cmd_q <= command; kind_q <= sensor_kind; irq_q <= irq_flags;
					smp_q[0] <= sample0; smp_q[1] <= sample1; smp_q[2] <= sample2;
				end
				SQ_DIV: begin
					st_o_q <= ST_OK; fc_o_q <= FC_NONE; push_o_q <= 1'b0;
					sen_o_q <= 1'b0; ovf_hit_q <= 1'b0;
					for (int i = 0; i < 3; i++) v_q[i] <= '0;
					ch_q <= 2'd0;
					if (!cmd_q) begin
						sen_o_q <= kind_q;
						case (ms_q)
							MS_ALS: begin
								if (kind_q) ms_q <= MS_ALS_PEND;
								st_o_q <= ST_BUSY;
							end
							MS_PS: begin
								if (!kind_q) ms_q <= MS_PS_PEND;
								st_o_q <= ST_BUSY;
							end
							MS_ALS_PEND, MS_PS_PEND: st_o_q <= ST_DENIED;
							default: begin
								ms_q <= kind_q ? MS_PS : MS_ALS;
								fc_o_q <= kind_q ? FC_PROX : FC_LIGHT;
								st_o_q <= ST_PROGRESS;
							end
						endcase
					end else if (ms_q inside {MS_ALS, MS_ALS_PEND, MS_PS, MS_PS_PEND}) begin
						sen_o_q <= ms_ps;
						sen_q   <= ms_ps;
						if (!rd_go) st_o_q <= ST_MISMATCH;
					end else begin
						st_o_q <= ST_IDLEIRQ;
					end
				end
				SQ_NEXT: if (raw == ovf_q) ovf_hit_q <= 1'b1;
				SQ_MUL: if (rsp.done) begin
					v_q[ch_q] <= rsp.value;
					ch_q <= ch_q + 2'd1;
				end
				SQ_CMP: begin
					if (sen_q) cov_q <= v_q[0] < cthr_q;
					if (sen_q || !cov_q) begin
						if (v_q[0] == last_q[base] &&
						    (!sen_q || nb < 2'd2 || v_q[1] == last_q[4]) &&
						    (!sen_q || nb < 2'd3 || v_q[2] == last_q[5])) begin
							// a fired pending request reports ok instead
							if (!pend) st_o_q <= ST_SAME;
						end else begin
							push_o_q <= 1'b1;
							for (int i = 0; i < 3; i++)
								last_q[base + 3'(i)] <= v_q[i];
						end
					end
				end
				default: ;
			endcase
			// advance the measurement after a read (overflow, covered or not)
			if ((sq_q == SQ_CMP) || (sq_q == SQ_NEXT && raw == ovf_q)) begin
				case (ms_q)
					MS_ALS_PEND: begin ms_q <= MS_PS; fc_o_q <= FC_PROX; end
					MS_PS_PEND:  begin ms_q <= MS_ALS; fc_o_q <= FC_LIGHT; end
					default:     ms_q <= MS_IDLE;
				endcase
			end
		end
	end

	// result port; values only when pushed
	assign in_ready   = (sq_q == SQ_IDLE);
	assign out_valid  = (sq_q == SQ_OUT);
	assign status     = st_o_q;
	assign force_cmd  = fc_o_q;
	assign pushed     = push_o_q && !ovf_hit_q;
	assign sensor_out = sen_o_q;
	assign value0     = pushed ? v_q[0] : '0;
	assign value1     = pushed ? v_q[1] : '0;
	assign value2     = pushed ? v_q[2] : '0;

endmodule
`default_nettype wire

// File: src/apms_calc.sv
// ----------------------------------------------------------------------------
// apms_calc: shared channel arithmetic
// Optional q = 65536/s by restoring division, one bit a cycle (else q = s),
// then q*whole + (q*frac)/10000 with saturation at 2^31-1; the division by
// 10000 is a shift by four and a reciprocal multiply for 625.
// ----------------------------------------------------------------------------
`default_nettype none
module apms_calc import apms_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire calc_req_t req,
	output calc_rsp_t      rsp
);

	typedef enum logic [2:0] {C_IDLE, C_DIV, C_MUL, C_RDIV, C_SUM} cst_t;

	cst_t        st_q;
	logic [4:0]  cnt_q;
	logic [16:0] den_q;
	logic [16:0] rem_q;
	logic [16:0] quo_q;
	logic [31:0] range_q;
	logic [32:0] pw_q;
	logic [28:0] pf_q;
	logic [19:0] fq_q;
	logic [VW-1:0] val_q;
	logic        done_q;

	logic [17:0] rem_sh;
	logic [32:0] pf_prod;
	logic [58:0] rcp_prod;

	// 65536 has a single set bit at position 16: bring it in first
	assign rem_sh = {rem_q, (cnt_q == 5'd16)};
	assign pf_prod = quo_q * range_q[15:0];
	// x/10000 == (x>>4)/625
	assign rcp_prod = pf_q * RCP_625;

	// iterative divide/scale sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= C_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				C_IDLE: begin
					if (req.start) begin
						range_q <= req.range;
						den_q   <= req.s;
						quo_q   <= req.s;
						rem_q   <= '0;
						cnt_q   <= 5'd16;
						st_q    <= req.invert ? C_DIV : C_MUL;
					end
				end
				C_DIV: begin
					if (rem_sh >= {1'b0, den_q}) begin
						rem_q <= 17'(rem_sh - {1'b0, den_q});
						quo_q <= {quo_q[15:0], 1'b1};
					end else begin
						rem_q <= rem_sh[16:0];
						quo_q <= {quo_q[15:0], 1'b0};
					end
					if (cnt_q == 5'd0) st_q <= C_MUL;
					else cnt_q <= cnt_q - 5'd1;
				end
				C_MUL: begin
					pw_q  <= 33'(quo_q * range_q[31:16]);
					pf_q  <= pf_prod[32:4];
					cnt_q <= 5'd0;
					st_q  <= C_RDIV;
				end
				C_RDIV: begin
					// quotient of the fraction product by 10000
					fq_q <= rcp_prod[58:39];
					st_q <= C_SUM;
				end
				C_SUM: begin
					done_q <= 1'b1;
					st_q   <= C_IDLE;
				end
				default: st_q <= C_IDLE;
			endcase
		end
	end

	// final add and saturate
	logic [33:0] sum;
	assign sum = {1'b0, pw_q} + {14'd0, fq_q};
	always_ff @(posedge clk) begin
		if (st_q == C_SUM)
			val_q <= (sum > 34'h7FFFFFFF) ? {VW{1'b1}} : sum[VW-1:0];
	end

	assign rsp.done  = done_q;
	assign rsp.value = val_q;

endmodule
`default_nettype wire
